/* sv/lse_pkg.sv */
// Shared types, codes and constants of the LSB stego extractor.
package lse_pkg;

  localparam int MAX_EXT_CHARS = 9;
  localparam int LENGTH_BYTES  = 4;

  localparam int EXT_CNT_W  = 4;
  localparam int LEN_W      = 31;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 2;

  localparam logic [7:0] CARRIER_FF  = 8'hFF;
  localparam logic [7:0] CARRIER_FE  = 8'hFE;
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;

  localparam logic [1:0] MODE_LSB1 = 2'd0;
  localparam logic [1:0] MODE_LSB4 = 2'd1;
  localparam logic [1:0] MODE_LSBE = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] CFG_EMBED_MODE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ENCRYPTED  = 2'd1;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_EXT      = 2'd1,
    KIND_LENGTH   = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_PAYLOAD = 4'b0010,
    PH_EXT     = 4'b0100,
    PH_DONE    = 4'b1000
  } phase_e;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } hid_byte_t;

  typedef struct packed {
    logic             vld;
    logic [7:0]       byte_value;
    kind_e            kind;
    logic [LEN_W-1:0] payload_length;
    logic             last;
  } result_t;

endpackage

/* sv/lsb_stego_extractor_unit.sv */
// Top level of the LSB stego extractor: input register, extraction logic, result register.
//
//  channel   | dir | handshake                    | payload
//  ----------+-----+------------------------------+----------------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready  | tdata carrier_byte, tuser restart
//  m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata byte_value,payload_length; tuser kind;
//            |     |                              | tlast last
//  cfg       | in  | cfg_valid_i/cfg_ready_o      | cfg_addr_i register index, cfg_data_i
//
//  One carrier word per cycle unless m_axis stalls; input and result are both registered.
//  The rate is set by the single state update between input and result register.
//  rst_ni resets the extraction state and clears embed_mode and encrypted_payload to zero.
//  A stalled m_axis holds the result register; the input register fills, then s_axis stalls.
//  Configuration writes are taken every cycle.
module lsb_stego_extractor_unit #(
  parameter int MaxExtChars = lse_pkg::MAX_EXT_CHARS,
  parameter int LengthBytes = lse_pkg::LENGTH_BYTES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] carrier_byte
  input  logic [0:0]                     s_axis_tuser,  // [0] restart
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [39:0]                    m_axis_tdata,  // [7:0] byte_value, [38:8] payload_length
  output logic [1:0]                     m_axis_tuser,  // [1:0] kind
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lse_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [lse_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lse_pkg::*;

  logic [1:0]       mode_q;
  logic             enc_q;
  logic             in_vld_q;
  logic [7:0]       in_byte_q;
  logic             in_rst_q;
  logic             adv;
  logic             active;
  hid_byte_t        hb;
  result_t          res;
  logic             out_vld_q;
  logic [7:0]       out_byte_q;
  kind_e            out_kind_q;
  logic [LEN_W-1:0] out_len_q;
  logic             out_last_q;

  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LSB1;
      enc_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_addr_i)
        CFG_EMBED_MODE: mode_q <= cfg_data_i[1:0];
        CFG_ENCRYPTED:  enc_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_rst_q  <= s_axis_tuser[0];
    end
  end

  lse_bit_gather u_gather (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv && active),
    .clear_i   (adv && in_rst_q),
    .mode_i    (mode_q),
    .carrier_i (in_byte_q),
    .hb_o      (hb)
  );

  lse_frame_ctrl #(
    .MaxExtChars (MaxExtChars),
    .LengthBytes (LengthBytes)
  ) u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .restart_i (in_rst_q),
    .enc_i     (enc_q),
    .hb_i      (hb),
    .active_o  (active),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= res.vld;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res.vld) begin
      out_byte_q <= res.byte_value;
      out_kind_q <= res.kind;
      out_len_q  <= res.payload_length;
      out_last_q <= res.last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_len_q, out_byte_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  a_overflow_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_OVERFLOW |-> m_axis_tlast)
    else $error("overflow result without tlast");

  a_len_only_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_LENGTH |-> m_axis_tdata[38:8] == '0)
    else $error("payload_length set outside a length report");

  a_len_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_LENGTH || m_axis_tuser == KIND_OVERFLOW)
    |-> m_axis_tdata[7:0] == 8'd0)
    else $error("byte_value set on a report word");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && out_vld_q && !m_axis_tready |=> in_vld_q && $stable(in_byte_q))
    else $error("input word lost during output stall");

endmodule

/* sv/lse_bit_gather.sv */
// Hidden-bit collector: shifts carrier bits into bytes per embed mode.
module lse_bit_gather (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               clear_i,
  input  logic [1:0]         mode_i,
  input  logic [7:0]         carrier_i,
  output lse_pkg::hid_byte_t hb_o
);
  import lse_pkg::*;

  logic [7:0] acc_q, acc_d, acc_b, nib;
  logic [3:0] cnt_q, cnt_d, cnt_b;

  always_comb begin
    acc_b = clear_i ? 8'd0 : acc_q;
    cnt_b = clear_i ? 4'd0 : cnt_q;
    acc_d = acc_b;
    cnt_d = cnt_b;
    nib   = carrier_i & NIBBLE_MASK;
    hb_o  = '0;
    if (step_i) begin
      case (mode_i)
        MODE_LSB4: begin
          acc_d = {acc_b[3:0], nib[3:0]};
          cnt_d = cnt_b + 4'd4;
        end
        MODE_LSBE: begin
          if (carrier_i == CARRIER_FF || carrier_i == CARRIER_FE) begin
            acc_d = {acc_b[6:0], carrier_i[0]};
            cnt_d = cnt_b + 4'd1;
          end
        end
        default: begin
          acc_d = {acc_b[6:0], carrier_i[0]};
          cnt_d = cnt_b + 4'd1;
        end
      endcase
      if (cnt_d >= 4'd8) begin
        hb_o.vld  = 1'b1;
        hb_o.data = acc_d;
        acc_d     = 8'd0;
        cnt_d     = 4'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 8'd0;
      cnt_q <= 4'd0;
    end else if (step_i || clear_i) begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* sv/lse_frame_ctrl.sv */
// Message framing: length header, payload count, extension and end of message.
module lse_frame_ctrl #(
  parameter int MaxExtChars = lse_pkg::MAX_EXT_CHARS,
  parameter int LengthBytes = lse_pkg::LENGTH_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               restart_i,
  input  logic               enc_i,
  input  lse_pkg::hid_byte_t hb_i,
  output logic               active_o,
  output lse_pkg::result_t   res_o
);
  import lse_pkg::*;

  phase_e                 phase_q, phase_d, phase_b;
  logic [31:0]            len_q, len_d, len_b, len_new, len_fix;
  logic [LEN_W-1:0]       cnt_q, cnt_d, cnt_b, cnt_inc;
  logic [EXT_CNT_W-1:0]   ext_q, ext_d, ext_b;

  always_comb begin
    phase_b  = restart_i ? PH_HEADER : phase_q;
    len_b    = restart_i ? 32'd0 : len_q;
    cnt_b    = restart_i ? '0 : cnt_q;
    ext_b    = restart_i ? '0 : ext_q;
    active_o = (phase_b != PH_DONE);
    phase_d  = phase_b;
    len_d    = len_b;
    cnt_d    = cnt_b;
    ext_d    = ext_b;
    cnt_inc  = cnt_b + LEN_W'(1);
    len_new  = {len_b[23:0], hb_i.data};
    len_fix  = len_new[31] ? 32'd0 : len_new;
    res_o    = '0;
    res_o.kind = KIND_PAYLOAD;
    if (hb_i.vld) begin
      case (phase_b)
        PH_HEADER: begin
          len_d = len_new;
          if (cnt_inc < LEN_W'(LengthBytes)) begin
            cnt_d = cnt_inc;
          end else begin
            len_d                = len_fix;
            cnt_d                = '0;
            res_o.vld            = 1'b1;
            res_o.kind           = KIND_LENGTH;
            res_o.payload_length = len_fix[LEN_W-1:0];
            if (len_fix != 32'd0) begin
              phase_d = PH_PAYLOAD;
            end else if (enc_i) begin
              phase_d    = PH_DONE;
              res_o.last = 1'b1;
            end else begin
              phase_d = PH_EXT;
            end
          end
        end
        PH_PAYLOAD: begin
          cnt_d            = cnt_inc;
          res_o.vld        = 1'b1;
          res_o.byte_value = hb_i.data;
          if (cnt_inc >= len_b[LEN_W-1:0]) begin
            phase_d    = enc_i ? PH_DONE : PH_EXT;
            res_o.last = enc_i;
          end
        end
        PH_EXT: begin
          res_o.vld = 1'b1;
          if (hb_i.data == 8'd0) begin
            phase_d    = PH_DONE;
            res_o.kind = KIND_EXT;
            res_o.last = 1'b1;
          end else if (ext_b >= EXT_CNT_W'(MaxExtChars)) begin
            phase_d    = PH_DONE;
            res_o.kind = KIND_OVERFLOW;
            res_o.last = 1'b1;
          end else begin
            ext_d            = ext_b + EXT_CNT_W'(1);
            res_o.kind       = KIND_EXT;
            res_o.byte_value = hb_i.data;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      len_q   <= 32'd0;
      cnt_q   <= '0;
      ext_q   <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      ext_q   <= ext_d;
    end
  end

endmodule
